// ===== design/ndjson_line_structure_checker_defines.svh =====
// assertion macros for the ndjson line structure checker
// no dependencies; included by the top level only
`ifndef NDJSON_LINE_STRUCTURE_CHECKER_DEFINES_SVH
`define NDJSON_LINE_STRUCTURE_CHECKER_DEFINES_SVH

`ifndef SYNTH
`define NLSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ndjson line checker assertion failed");
`define NLSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ndjson line checker assertion failed");
`else
`define NLSC_ASSERT(lbl, clk, rst_n, prop)
`define NLSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/nlsc_pkg.sv =====
// shared types and constants for the ndjson line structure checker
// no dependencies
package nlsc_pkg;

  localparam int NEST_LIMIT_DEF = 128;

  // input commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // held status codes
  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_VALID = 2'd1,
    ST_BAD   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // character codes
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;

  // decoded view of one byte
  typedef struct packed {
    logic is_lf;
    logic is_cr;
    logic is_ws;
    logic is_ctrl;
    logic is_quote;
    logic is_bslash;
    logic is_lbrace;
    logic is_lbracket;
    logic is_rbrace;
    logic is_rbracket;
  } byte_class_t;

  // closer stack request: push or pop, and the closer kind pushed (1 = brace)
  typedef struct packed {
    logic push;
    logic pop;
    logic brace;
  } stack_op_t;

endpackage

// ===== design/nlsc_byte_class.sv =====
// byte decoder for the ndjson line structure checker
// depends on nlsc_pkg
module nlsc_byte_class (
  input  logic [7:0]           byte_value,
  output nlsc_pkg::byte_class_t cls
);

  always_comb begin
    cls.is_lf       = (byte_value == nlsc_pkg::CH_LF);
    cls.is_cr       = (byte_value == nlsc_pkg::CH_CR);
    // tab through carriage return, and space
    cls.is_ws       = (byte_value == nlsc_pkg::CH_SPACE) ||
                      ((byte_value >= nlsc_pkg::CH_TAB) && (byte_value <= nlsc_pkg::CH_CR));
    cls.is_ctrl     = (byte_value < nlsc_pkg::CH_SPACE);
    cls.is_quote    = (byte_value == nlsc_pkg::CH_QUOTE);
    cls.is_bslash   = (byte_value == nlsc_pkg::CH_BSLASH);
    cls.is_lbrace   = (byte_value == nlsc_pkg::CH_LBRACE);
    cls.is_lbracket = (byte_value == nlsc_pkg::CH_LBRACKET);
    cls.is_rbrace   = (byte_value == nlsc_pkg::CH_RBRACE);
    cls.is_rbracket = (byte_value == nlsc_pkg::CH_RBRACKET);
  end

endmodule

// ===== design/nlsc_closer_stack.sv =====
// expected-closer stack as a shift line, top always at entry 0
// depends on nlsc_pkg
module nlsc_closer_stack #(
  parameter int NEST_LIMIT = nlsc_pkg::NEST_LIMIT_DEF
) (
  input  logic                clk,
  input  nlsc_pkg::stack_op_t op,
  output logic                top_brace
);

  logic [NEST_LIMIT-1:0] stk_r;
  logic [NEST_LIMIT-1:0] stk_nxt;

  // push shifts toward the bottom, pop shifts toward the top
  for (genvar i = 0; i < NEST_LIMIT; i++) begin : g_entry
    logic from_above;
    logic from_below;
    if (i == 0) begin : g_first
      assign from_above = op.brace;
    end else begin : g_rest
      assign from_above = stk_r[i-1];
    end
    if (i == NEST_LIMIT - 1) begin : g_last
      assign from_below = stk_r[i];
    end else begin : g_mid
      assign from_below = stk_r[i+1];
    end
    always_comb begin
      if (op.push) begin
        stk_nxt[i] = from_above;
      end else if (op.pop) begin
        stk_nxt[i] = from_below;
      end else begin
        stk_nxt[i] = stk_r[i];
      end
    end
  end

  // contents need no reset: an entry is read only after it was pushed
  always_ff @(posedge clk) begin
    stk_r <= stk_nxt;
  end

  assign top_brace = stk_r[0];

endmodule

// ===== design/ndjson_line_structure_checker.sv =====
// ndjson line structure checker: one result per byte, result valid in the cycle after
// request accept; one request per cycle while results are taken, the closer stack top
// and all line flags are updated together on each accept from registered state
// reset (synchronous, rst_n low) clears counters, flags and status; stack
// contents are not cleared and need no clearing pass
// depends on nlsc_pkg, nlsc_byte_class, nlsc_closer_stack and the defines header
`include "ndjson_line_structure_checker_defines.svh"

module ndjson_line_structure_checker #(
  parameter int NEST_LIMIT = nlsc_pkg::NEST_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_line_number,
  output logic [31:0] out_record_count,
  output logic [7:0]  out_nest_depth
);

  localparam int DEPTH_W = $clog2(NEST_LIMIT + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(NEST_LIMIT);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

  // per-line state
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic text_seen_r, text_seen_nxt;
  logic started_r, started_nxt;
  logic complete_r, complete_nxt;
  logic in_str_r, in_str_nxt;
  logic esc_r, esc_nxt;
  // stream state; these registers also serve as the result register
  logic [31:0] line_r, line_nxt;
  logic [31:0] rec_r, rec_nxt;
  nlsc_pkg::status_t status_r, status_nxt;
  logic out_valid_r;

  logic                  accept;
  logic                  line_ok;
  logic                  top_brace;
  nlsc_pkg::byte_class_t cls;
  nlsc_pkg::stack_op_t   sop;
  logic [DEPTH_W+7:0]    depth_wide;

  // a new request is taken whenever the result slot is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  nlsc_byte_class u_byte_class (
    .byte_value (in_byte_value),
    .cls        (cls)
  );

  nlsc_closer_stack #(
    .NEST_LIMIT (NEST_LIMIT)
  ) u_closer_stack (
    .clk       (clk),
    .op        (sop),
    .top_brace (top_brace)
  );

  // an empty line passes; otherwise the object must be closed and strings shut
  assign line_ok = (!text_seen_r && !started_r) ||
                   (started_r && complete_r && !in_str_r && !esc_r && (depth_r == '0));

  always_comb begin
    depth_nxt     = depth_r;
    text_seen_nxt = text_seen_r;
    started_nxt   = started_r;
    complete_nxt  = complete_r;
    in_str_nxt    = in_str_r;
    esc_nxt       = esc_r;
    line_nxt      = line_r;
    rec_nxt       = rec_r;
    status_nxt    = status_r;
    sop           = '0;

    // once not running, everything is frozen until reset
    if (accept && (status_r == nlsc_pkg::ST_RUN)) begin
      if (in_command == nlsc_pkg::CMD_END) begin
        // end of stream closes the last line
        if (!line_ok) begin
          status_nxt = nlsc_pkg::ST_BAD;
        end else begin
          if (started_r && (rec_r != '1)) begin
            rec_nxt = rec_r + 32'd1;
          end
          status_nxt = (rec_nxt == '0) ? nlsc_pkg::ST_EMPTY : nlsc_pkg::ST_VALID;
        end
      end else if (cls.is_lf) begin
        if (!line_ok) begin
          status_nxt = nlsc_pkg::ST_BAD;
        end else begin
          if (started_r && (rec_r != '1)) begin
            rec_nxt = rec_r + 32'd1;
          end
          depth_nxt     = '0;
          text_seen_nxt = 1'b0;
          started_nxt   = 1'b0;
          complete_nxt  = 1'b0;
          in_str_nxt    = 1'b0;
          esc_nxt       = 1'b0;
          if (line_r != '1) begin
            line_nxt = line_r + 32'd1;
          end
        end
      end else if (cls.is_cr) begin
        // skipped outside strings, no content
        if (in_str_r) begin
          status_nxt = nlsc_pkg::ST_BAD;
        end
      end else if (!started_r) begin
        // before the opener only whitespace or an opening brace
        if (cls.is_ws) begin
          text_seen_nxt = 1'b1;
        end else if (!cls.is_lbrace) begin
          status_nxt = nlsc_pkg::ST_BAD;
        end else begin
          text_seen_nxt = 1'b1;
          started_nxt   = 1'b1;
          depth_nxt     = DEPTH_ONE;
          sop.push      = 1'b1;
          sop.brace     = 1'b1;
        end
      end else begin
        text_seen_nxt = 1'b1;
        if (complete_r) begin
          // trailing text after the object
          if (!cls.is_ws) begin
            status_nxt = nlsc_pkg::ST_BAD;
          end
        end else if (in_str_r) begin
          if (cls.is_ctrl) begin
            status_nxt = nlsc_pkg::ST_BAD;
          end else if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (cls.is_bslash) begin
            esc_nxt = 1'b1;
          end else if (cls.is_quote) begin
            in_str_nxt = 1'b0;
          end
        end else if (cls.is_quote) begin
          in_str_nxt = 1'b1;
        end else if (cls.is_lbrace || cls.is_lbracket) begin
          // nesting overflow
          if (depth_r >= DEPTH_MAX) begin
            status_nxt = nlsc_pkg::ST_BAD;
          end else begin
            sop.push  = 1'b1;
            sop.brace = cls.is_lbrace;
            depth_nxt = depth_r + DEPTH_ONE;
          end
        end else if (cls.is_rbrace || cls.is_rbracket) begin
          // closer must match the stack top
          if ((depth_r == '0) || (top_brace != cls.is_rbrace)) begin
            status_nxt = nlsc_pkg::ST_BAD;
          end else begin
            sop.pop   = 1'b1;
            depth_nxt = depth_r - DEPTH_ONE;
            if (depth_r == DEPTH_ONE) begin
              complete_nxt = 1'b1;
            end
          end
        end else if (cls.is_ctrl && !cls.is_ws) begin
          status_nxt = nlsc_pkg::ST_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      text_seen_r <= 1'b0;
      started_r   <= 1'b0;
      complete_r  <= 1'b0;
      in_str_r    <= 1'b0;
      esc_r       <= 1'b0;
      line_r      <= 32'd1;
      rec_r       <= '0;
      status_r    <= nlsc_pkg::ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      text_seen_r <= text_seen_nxt;
      started_r   <= started_nxt;
      complete_r  <= complete_nxt;
      in_str_r    <= in_str_nxt;
      esc_r       <= esc_nxt;
      line_r      <= line_nxt;
      rec_r       <= rec_nxt;
      status_r    <= status_nxt;
      // result slot fills on accept, empties when taken
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // state only moves on accept, so it always matches the pending result
  assign depth_wide       = {8'd0, depth_r};
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_line_number  = line_r;
  assign out_record_count = rec_r;
  assign out_nest_depth   = depth_wide[7:0];

  // checks
  `NLSC_ASSERT_NEXT(a_frozen, clk, rst_n, status_r != nlsc_pkg::ST_RUN,
                    $stable(status_r) && $stable(line_r) && $stable(rec_r))
  `NLSC_ASSERT(a_depth_bound, clk, rst_n, depth_r <= DEPTH_MAX)
  `NLSC_ASSERT(a_complete_closed, clk, rst_n, !complete_r || (started_r && (depth_r == '0)))
  `NLSC_ASSERT_NEXT(a_rec_step, clk, rst_n, 1'b1,
                    (rec_r == $past(rec_r)) || (rec_r == $past(rec_r) + 32'd1))
  `NLSC_ASSERT_NEXT(a_idle_no_change, clk, rst_n, !accept,
                    $stable(depth_r) && $stable(status_r) && $stable(line_r))

endmodule

// ===== test/nlsc_result_checker.sv =====
// result checker for the ndjson line structure checker: predicts every result from
// the accepted requests and compares it with what the block returns
// depends on nlsc_pkg
module nlsc_result_checker #(
  parameter int NEST_LIMIT = nlsc_pkg::NEST_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_byte_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_line_number,
  input  logic [31:0] out_record_count,
  input  logic [7:0]  out_nest_depth,
  output int          mismatch_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import nlsc_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] line_number;
    logic [31:0] records;
    logic [7:0]  nest_depth;
  } line_report_t;

  // parser state as the block should hold it
  logic         closer_is_brace [NEST_LIMIT];
  int           open_depth;
  logic         saw_text;
  logic         object_started;
  logic         object_done;
  logic         string_open;
  logic         escaped;
  logic [31:0]  line_no;
  logic [31:0]  records_done;
  status_t      held;
  line_report_t pending_reports[$];

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [31:0] bump_saturating(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void clear_line_state();
    open_depth     = 0;
    saw_text       = 1'b0;
    object_started = 1'b0;
    object_done    = 1'b0;
    string_open    = 1'b0;
    escaped        = 1'b0;
  endfunction

  // empty lines pass, anything else must be one finished object
  function automatic bit line_closes_clean();
    if (!saw_text && !object_started) return 1'b1;
    return object_started && object_done && !string_open && !escaped && open_depth == 0;
  endfunction

  // one non-newline byte; returns 0 when the byte breaks the line
  function automatic bit take_char(logic [7:0] c);
    if (c == CH_CR) return !string_open;
    if (!object_started) begin
      if (is_space(c)) begin
        saw_text = 1'b1;
        return 1'b1;
      end
      if (c != CH_LBRACE) return 1'b0;
      saw_text           = 1'b1;
      object_started     = 1'b1;
      closer_is_brace[0] = 1'b1;
      open_depth         = 1;
      return 1'b1;
    end
    saw_text = 1'b1;
    if (object_done) return is_space(c);
    if (string_open) begin
      if (c < CH_SPACE) return 1'b0;
      if (escaped) escaped = 1'b0;
      else if (c == CH_BSLASH) escaped = 1'b1;
      else if (c == CH_QUOTE) string_open = 1'b0;
      return 1'b1;
    end
    if (c == CH_QUOTE) begin
      string_open = 1'b1;
    end else if (c == CH_LBRACE || c == CH_LBRACKET) begin
      if (open_depth >= NEST_LIMIT) return 1'b0;
      closer_is_brace[open_depth] = (c == CH_LBRACE);
      open_depth++;
    end else if (c == CH_RBRACE || c == CH_RBRACKET) begin
      if (open_depth == 0 || open_depth > NEST_LIMIT) return 1'b0;
      if (closer_is_brace[open_depth-1] != (c == CH_RBRACE)) return 1'b0;
      open_depth--;
      if (open_depth == 0) object_done = 1'b1;
    end else if (c < CH_SPACE && !is_space(c)) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic line_report_t predict_report(logic cmd, logic [7:0] c);
    line_report_t r;
    if (held == ST_RUN) begin
      if (cmd == CMD_END || c == CH_LF) begin
        if (!line_closes_clean()) begin
          held = ST_BAD;
        end else begin
          if (object_started) records_done = bump_saturating(records_done);
          if (cmd == CMD_END) begin
            held = (records_done == 32'd0) ? ST_EMPTY : ST_VALID;
          end else begin
            clear_line_state();
            line_no = bump_saturating(line_no);
          end
        end
      end else if (!take_char(c)) begin
        held = ST_BAD;
      end
    end
    r.status      = held;
    r.line_number = line_no;
    r.records     = records_done;
    r.nest_depth  = 8'(open_depth);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    line_report_t want;
    if (!rst_n) begin
      clear_line_state();
      line_no        = 32'd1;
      records_done   = 32'd0;
      held           = ST_RUN;
      mismatch_count = 0;
      pending_reports.delete();
    end else begin
      // results leave before the request of this edge can have produced one
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          flag_mismatch("unrequested result", {30'd0, out_status}, 32'd0);
        end else begin
          want = pending_reports.pop_front();
          if (out_status != want.status)
            flag_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
          if (out_line_number != want.line_number)
            flag_mismatch("line_number", out_line_number, want.line_number);
          if (out_record_count != want.records)
            flag_mismatch("records", out_record_count, want.records);
          if (out_nest_depth != want.nest_depth)
            flag_mismatch("nest_depth", {24'd0, out_nest_depth}, {24'd0, want.nest_depth});
        end
      end
      if (in_valid && in_ready)
        pending_reports.push_back(predict_report(in_command, in_byte_value));
    end
    results_pending <= pending_reports.size();
  end

endmodule

// ===== test/tb_top.sv =====
// top of the ndjson line structure checker testbench: clock, reset, request
// stimulus, result backpressure and the verdict
// depends on nlsc_pkg, the block and nlsc_result_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nlsc_pkg::*;

  localparam int NEST            = NEST_LIMIT_DEF;
  // bound for the watchdog, well above the length of the slowest run
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int LONG_STALL      = 300;
  // block answers in the cycle after accepting a request; spare drain time
  localparam int DRAIN_CYCLES    = 8;
  localparam int FROZEN_REQUESTS = 20;

  localparam logic [7:0] CH_VTAB     = 8'h0B;
  localparam logic [7:0] CH_FFEED    = 8'h0C;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
  localparam logic [7:0] CH_MAX      = 8'hFF;

  // how the stream is brought to its end
  typedef enum int {
    ENDING_CLEAN,
    ENDING_OPEN_LINE,
    ENDING_BAD_OPENER,
    ENDING_WRONG_CLOSER,
    ENDING_CTRL_OUTSIDE,
    ENDING_CR_IN_STRING,
    ENDING_CTRL_IN_STRING,
    ENDING_TRAILING_JUNK,
    ENDING_BLANK_LINE,
    ENDING_NEST_OVERFLOW,
    ENDING_OPEN_STRING,
    ENDING_ESCAPE_AT_END
  } stream_ending_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [7:0]  in_byte_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_line_number;
  logic [31:0] out_record_count;
  logic [7:0]  out_nest_depth;

  int mismatch_count;
  int results_pending;
  int cycle_count = 0;
  int requests_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_ticket = 0;
  int stall_seen = 0;

  // line under construction and the closer stack of the generator
  logic [7:0] line_bytes[$];
  bit         gen_brace [NEST];
  int         gen_depth;

  ndjson_line_structure_checker #(.NEST_LIMIT(NEST)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_byte_value    (in_byte_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_line_number  (out_line_number),
    .out_record_count (out_record_count),
    .out_nest_depth   (out_nest_depth)
  );

  nlsc_result_checker #(.NEST_LIMIT(NEST)) u_result_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_byte_value    (in_byte_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_line_number  (out_line_number),
    .out_record_count (out_record_count),
    .out_nest_depth   (out_nest_depth),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random ready, or a long hold-off whenever the stimulus
  // bumps the stall ticket
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_ticket != stall_seen) begin
        stall_seen = stall_ticket;
        out_ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one request; valid stays up from one request to the next unless an
  // idle cycle is drawn in between
  task automatic send_request(input logic cmd, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_byte_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic flush_line();
    foreach (line_bytes[i]) send_request(CMD_DATA, line_bytes[i]);
    line_bytes.delete();
  endtask

  // whitespace other than newline; carriage return is skipped by the block
  task automatic add_ws();
    case ($urandom_range(4))
      0: line_bytes.push_back(CH_SPACE);
      1: line_bytes.push_back(CH_TAB);
      2: line_bytes.push_back(CH_VTAB);
      3: line_bytes.push_back(CH_FFEED);
      default: line_bytes.push_back(CH_CR);
    endcase
  endtask

  // printable or high byte that is neither a quote nor a bracket of any kind
  task automatic add_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_MAX, CH_SPACE));
    while (c == CH_QUOTE || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_LBRACKET || c == CH_RBRACKET);
    line_bytes.push_back(c);
  endtask

  // quoted string with random content and escapes, including escaped quotes
  task automatic add_string();
    logic [7:0] c;
    line_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      if ($urandom_range(3) == 0) begin
        line_bytes.push_back(CH_BSLASH);
        line_bytes.push_back(8'($urandom_range(CH_MAX, CH_SPACE)));
      end else begin
        do c = 8'($urandom_range(CH_MAX, CH_SPACE));
        while (c == CH_QUOTE || c == CH_BSLASH);
        line_bytes.push_back(c);
      end
    end
    line_bytes.push_back(CH_QUOTE);
  endtask

  task automatic start_object();
    line_bytes.push_back(CH_LBRACE);
    gen_brace[0] = 1'b1;
    gen_depth    = 1;
  endtask

  task automatic add_opener();
    gen_brace[gen_depth] = $urandom_range(1);
    line_bytes.push_back(gen_brace[gen_depth] ? CH_LBRACE : CH_LBRACKET);
    gen_depth++;
  endtask

  task automatic add_closer();
    gen_depth--;
    line_bytes.push_back(gen_brace[gen_depth] ? CH_RBRACE : CH_RBRACKET);
  endtask

  // one well-formed line: mostly shallow objects, now and then the full nesting
  task automatic build_random_line();
    int max_depth;
    int steps;
    if ($urandom_range(3) == 0) add_ws();
    start_object();
    if ($urandom_range(49) == 0) begin
      max_depth = NEST;
      steps     = 0;
      while (gen_depth < NEST) begin
        if ($urandom_range(7) == 0) add_string();
        add_opener();
      end
    end else begin
      max_depth = $urandom_range(6, 1);
      steps     = $urandom_range(14);
    end
    repeat (steps) begin
      case ($urandom_range(4))
        0: if (gen_depth < max_depth) add_opener();
        1: if (gen_depth > 1) add_closer();
        2: add_string();
        3: add_plain();
        default: add_ws();
      endcase
    end
    while (gen_depth > 0) add_closer();
    if ($urandom_range(3) == 0) add_ws();
    line_bytes.push_back(CH_LF);
  endtask

  initial begin
    int             phase;
    bit             empty_stream;
    bit             end_request;
    logic [7:0]     pick;
    stream_ending_t ending;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_command    <= CMD_DATA;
    in_byte_value <= 8'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // now and then the whole stream is empty lines, ending with no records
    empty_stream = ($urandom_range(7) == 0);
    send_idle_pct = 34;
    recv_idle_pct <= 84;

    // directed opening: bare and carriage-return empty lines, then unless the
    // stream stays empty the smallest object and one with leading space, an
    // escaped quote, a high byte, an array and trailing whitespace
    line_bytes = '{CH_LF, CH_CR, CH_LF};
    if (!empty_stream) begin
      line_bytes.push_back(CH_LBRACE);
      line_bytes.push_back(CH_RBRACE);
      line_bytes.push_back(CH_LF);
      line_bytes.push_back(CH_SPACE);
      line_bytes.push_back(CH_LBRACE);
      line_bytes.push_back(CH_QUOTE);
      line_bytes.push_back(CH_BSLASH);
      line_bytes.push_back(CH_QUOTE);
      line_bytes.push_back(CH_MAX);
      line_bytes.push_back(CH_QUOTE);
      line_bytes.push_back(CH_LBRACKET);
      line_bytes.push_back(CH_RBRACKET);
      line_bytes.push_back(CH_RBRACE);
      line_bytes.push_back(CH_TAB);
      line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_LF);
    end
    flush_line();

    // three idle profiles; the last one opens with the long receiver hold-off
    // while requests keep coming, so the block has to push back
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct <= 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct <= 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          stall_ticket  <= stall_ticket + 1;
        end
      endcase
      while (requests_sent < (phase + 1) * ITEMS_PER_PHASE) begin
        if (empty_stream) begin
          if ($urandom_range(1)) line_bytes.push_back(CH_CR);
          line_bytes.push_back(CH_LF);
        end else if ($urandom_range(15) == 0) begin
          line_bytes.push_back(CH_LF);
        end else begin
          build_random_line();
        end
        flush_line();
      end
    end

    // the stream is closed by exactly one ending; status then freezes
    ending      = empty_stream ? ENDING_CLEAN
                               : stream_ending_t'($urandom_range(ENDING_ESCAPE_AT_END));
    end_request = 1'b0;
    case (ending)
      ENDING_CLEAN: begin
        if (!empty_stream && $urandom_range(1)) begin
          start_object();
          add_string();
          add_closer();
        end
        end_request = 1'b1;
      end
      ENDING_OPEN_LINE: begin
        start_object();
        add_opener();
        end_request = 1'b1;
      end
      ENDING_BAD_OPENER: begin
        if ($urandom_range(1)) add_ws();
        do pick = 8'($urandom_range(CH_MAX));
        while (pick == CH_LBRACE || pick == CH_SPACE || (pick >= CH_TAB && pick <= CH_CR));
        line_bytes.push_back(pick);
      end
      ENDING_WRONG_CLOSER: begin
        start_object();
        if ($urandom_range(1)) add_opener();
        line_bytes.push_back(gen_brace[gen_depth-1] ? CH_RBRACKET : CH_RBRACE);
      end
      ENDING_CTRL_OUTSIDE: begin
        start_object();
        do pick = 8'($urandom_range(CH_CTRL_MAX));
        while (pick >= CH_TAB && pick <= CH_CR);
        line_bytes.push_back(pick);
      end
      ENDING_CR_IN_STRING: begin
        start_object();
        line_bytes.push_back(CH_QUOTE);
        add_plain();
        line_bytes.push_back(CH_CR);
      end
      ENDING_CTRL_IN_STRING: begin
        start_object();
        line_bytes.push_back(CH_QUOTE);
        do pick = 8'($urandom_range(CH_CTRL_MAX));
        while (pick == CH_LF || pick == CH_CR);
        line_bytes.push_back(pick);
      end
      ENDING_TRAILING_JUNK: begin
        // a closer here is also a closer at depth zero
        start_object();
        add_closer();
        if ($urandom_range(1)) add_ws();
        do pick = 8'($urandom_range(CH_MAX));
        while (pick == CH_SPACE || (pick >= CH_TAB && pick <= CH_CR));
        line_bytes.push_back(pick);
      end
      ENDING_BLANK_LINE: begin
        line_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        add_ws();
        line_bytes.push_back(CH_LF);
      end
      ENDING_NEST_OVERFLOW: begin
        start_object();
        while (gen_depth < NEST) add_opener();
        line_bytes.push_back($urandom_range(1) ? CH_LBRACE : CH_LBRACKET);
      end
      ENDING_OPEN_STRING: begin
        start_object();
        line_bytes.push_back(CH_QUOTE);
        add_plain();
        line_bytes.push_back(CH_LF);
      end
      default: begin
        // backslash pending when the stream ends
        start_object();
        line_bytes.push_back(CH_QUOTE);
        line_bytes.push_back(CH_BSLASH);
        end_request = 1'b1;
      end
    endcase
    flush_line();
    if (end_request) send_request(CMD_END, 8'($urandom_range(CH_MAX)));

    // frozen block: everything it gets now is ignored
    repeat (FROZEN_REQUESTS)
      send_request(logic'($urandom_range(1)), 8'($urandom_range(CH_MAX)));
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
